// ===== src/epoch_gated_ring_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ring allocator
// Implication checks sampled on the rising clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EPOCH_GATED_RING_ALLOCATOR_CORE_ASSERT_SVH
`define EPOCH_GATED_RING_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define ERGA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring allocator check failed");

// next-cycle implication
`define ERGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring allocator check failed");

`endif

// ===== src/erga_pkg.sv =====
// ----------------------------------------------------------------------------
// erga_pkg
// Shared codes, reset values and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package erga_pkg;

   localparam int          CHECKPOINT_DEPTH_DEFAULT = 16;
   localparam logic [31:0] RING_CAPACITY_RESET      = 32'd16777216;

   localparam logic [1:0] OP_RESERVE  = 2'd0;
   localparam logic [1:0] OP_CLOSE    = 2'd1;
   localparam logic [1:0] OP_COMPLETE = 2'd2;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_SPACE    = 2'd1;
   localparam logic [1:0] ST_QUEUE_FULL  = 2'd2;

   typedef struct packed {
      logic load;
      logic cfg_write;
      logic grant;
      logic add_end;
      logic sub_freed;
      logic commit;
      logic close;
      logic ret_pop;
      logic ret_done;
      logic void_op;
   } erga_cmd_type;

   typedef struct packed {
      logic ret_more;
   } erga_stat_type;

endpackage

`default_nettype wire

// ===== src/epoch_gated_ring_allocator_core.sv =====
// ----------------------------------------------------------------------------
// epoch_gated_ring_allocator_core
// Ring-space allocator with epoch checkpoints and watermark reclaim.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on req_* with start; it is taken when busy is low.
//   Operation reserve grants bytes up to the ring end, close records a
//   checkpoint, complete retires checkpoints up to the given epoch.
//   Each item yields one result on rsp_* for one cycle with rsp_strobe.
//   Reserve: result strobe after the grant, add, subtract and compare
//   steps on the 64-bit cursors. Close and unknown: strobe after their step.
//   Complete: wait and check steps per checkpoint; each retire step
//   waits on the registered read of the checkpoint memory.
//   A new item can be taken in the cycle the result strobe is high.
//   The receiver cannot stall; results must be taken when strobed.
//   csr_data sets the ring capacity when csr_valid and csr_ready are high;
//   csr_ready is high while idle. A write also empties the ring and queue.
//   Reset: capacity 16777216, cursors zero, queue empty, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "epoch_gated_ring_allocator_core_assert.svh"

module epoch_gated_ring_allocator_core
   import erga_pkg::*;
#(
   parameter int CHECKPOINT_DEPTH = CHECKPOINT_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_request_size,
   input  wire logic [31:0] req_epoch_id,
   output      logic        rsp_strobe,
   output      logic [31:0] rsp_grant_offset,
   output      logic [31:0] rsp_grant_bytes,
   output      logic [1:0]  rsp_status,
   output      logic [4:0]  rsp_retired_count,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [31:0] csr_data
);

   erga_cmd_type  cmd;
   erga_stat_type stat;

   erga_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .csr_valid     (csr_valid),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy),
      .csr_ready     (csr_ready),
      .rsp_strobe    (rsp_strobe)
   );

   erga_datapath #(
      .CHECKPOINT_DEPTH (CHECKPOINT_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_request_size  (req_request_size),
      .req_epoch_id      (req_epoch_id),
      .csr_data          (csr_data),
      .rsp_grant_offset  (rsp_grant_offset),
      .rsp_grant_bytes   (rsp_grant_bytes),
      .rsp_status        (rsp_status),
      .rsp_retired_count (rsp_retired_count)
   );

   `ERGA_ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `ERGA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe)
   `ERGA_ASSERT_IMPLY(a_refuse_zero, clock, reset, rsp_strobe && rsp_status == ST_NO_SPACE,
      rsp_grant_bytes == 32'd0 && rsp_grant_offset == 32'd0)
   `ERGA_ASSERT_IMPLY(a_grant_ok, clock, reset, rsp_strobe && rsp_grant_bytes != 32'd0,
      rsp_status == ST_OK && rsp_retired_count == 5'd0)

endmodule

`default_nettype wire

// ===== src/erga_datapath.sv =====
// ----------------------------------------------------------------------------
// erga_datapath
// Cursors, ring offset, checkpoint queue memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module erga_datapath
   import erga_pkg::*;
#(
   parameter int CHECKPOINT_DEPTH = CHECKPOINT_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire erga_cmd_type  cmd,
   output      erga_stat_type stat,
   input  wire logic [1:0]    req_operation,
   input  wire logic [31:0]   req_request_size,
   input  wire logic [31:0]   req_epoch_id,
   input  wire logic [31:0]   csr_data,
   output      logic [31:0]   rsp_grant_offset,
   output      logic [31:0]   rsp_grant_bytes,
   output      logic [1:0]    rsp_status,
   output      logic [4:0]    rsp_retired_count
);

   localparam int AW = $clog2(CHECKPOINT_DEPTH);
   localparam int CW = $clog2(CHECKPOINT_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(CHECKPOINT_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CHECKPOINT_DEPTH);

   logic [31:0]   cap_ff;
   logic [63:0]   wcur_ff;
   logic [63:0]   fcur_ff;
   logic [31:0]   offset_ff;
   logic [AW-1:0] head_ff;
   logic [AW-1:0] tail_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] retired_ff;

   logic [1:0]    op_ff;
   logic [31:0]   size_ff;
   logic [31:0]   epoch_ff;
   logic [31:0]   granted_ff;
   logic [63:0]   end_ff;
   logic [63:0]   diff_ff;

   logic [95:0]   mem [CHECKPOINT_DEPTH];
   logic [95:0]   rd_ff;

   logic [31:0]   cap_eff;
   logic [31:0]   room;
   logic [32:0]   offset_sum_in;
   logic          refuse;
   logic          queue_full;
   logic [31:0]   rd_epoch;
   logic [63:0]   rd_end;

   assign cap_eff       = (cap_ff == 32'd0) ? 32'd1 : cap_ff;
   assign room          = cap_eff - offset_ff;
   assign offset_sum_in = {1'b0, offset_ff} + {1'b0, granted_ff};
   assign refuse        = diff_ff > {32'd0, cap_eff};
   assign queue_full    = count_ff == FULL_COUNT;
   assign rd_epoch      = rd_ff[95:64];
   assign rd_end        = rd_ff[63:0];
   assign stat.ret_more = (count_ff != '0) && (rd_epoch <= epoch_ff);

   always_ff @(posedge clock) begin
      if (cmd.close && !queue_full) begin
         mem[tail_ff] <= {epoch_ff, wcur_ff};
      end
      rd_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= RING_CAPACITY_RESET;
         wcur_ff    <= '0;
         fcur_ff    <= '0;
         offset_ff  <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         retired_ff <= '0;
      end else begin
         if (cmd.cfg_write) begin
            cap_ff    <= csr_data;
            wcur_ff   <= '0;
            fcur_ff   <= '0;
            offset_ff <= '0;
            head_ff   <= '0;
            tail_ff   <= '0;
            count_ff  <= '0;
         end
         if (cmd.load) begin
            retired_ff <= '0;
         end
         if (cmd.commit && !refuse) begin
            wcur_ff   <= end_ff;
            offset_ff <= (offset_sum_in == {1'b0, cap_eff}) ? 32'd0 : offset_sum_in[31:0];
         end
         if (cmd.close && !queue_full) begin
            tail_ff  <= (tail_ff == LAST_SLOT) ? '0 : tail_ff + AW'(1);
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.ret_pop) begin
            fcur_ff    <= rd_end;
            head_ff    <= (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
            count_ff   <= count_ff - CW'(1);
            retired_ff <= retired_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         size_ff  <= req_request_size;
         epoch_ff <= req_epoch_id;
      end
      if (cmd.grant) begin
         granted_ff <= (size_ff < room) ? size_ff : room;
      end
      if (cmd.add_end) begin
         end_ff <= wcur_ff + {32'd0, granted_ff};
      end
      if (cmd.sub_freed) begin
         diff_ff <= end_ff - fcur_ff;
      end
      if (cmd.commit) begin
         rsp_grant_offset  <= refuse ? 32'd0 : offset_ff;
         rsp_grant_bytes   <= refuse ? 32'd0 : granted_ff;
         rsp_status        <= refuse ? ST_NO_SPACE : ST_OK;
         rsp_retired_count <= '0;
      end
      if (cmd.close) begin
         rsp_grant_offset  <= '0;
         rsp_grant_bytes   <= '0;
         rsp_status        <= queue_full ? ST_QUEUE_FULL : ST_OK;
         rsp_retired_count <= '0;
      end
      if (cmd.ret_done) begin
         rsp_grant_offset  <= '0;
         rsp_grant_bytes   <= '0;
         rsp_status        <= ST_OK;
         rsp_retired_count <= 5'(retired_ff);
      end
      if (cmd.void_op) begin
         rsp_grant_offset  <= '0;
         rsp_grant_bytes   <= '0;
         rsp_status        <= (op_ff == OP_RESERVE) ? ST_NO_SPACE : ST_OK;
         rsp_retired_count <= '0;
      end
   end

endmodule

`default_nettype wire

// ===== src/erga_controller.sv =====
// ----------------------------------------------------------------------------
// erga_controller
// Sequences reserve, close and retire steps and marks each result.
// ----------------------------------------------------------------------------
`default_nettype none

module erga_controller
   import erga_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [1:0]    req_operation,
   input  wire logic          csr_valid,
   input  wire erga_stat_type stat,
   output      erga_cmd_type  cmd,
   output      logic          busy,
   output      logic          csr_ready,
   output      logic          rsp_strobe
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_GRANT,
      S_ADD,
      S_SUB,
      S_COMMIT,
      S_CLOSE,
      S_RET_WAIT,
      S_RET_CHECK,
      S_VOID
   } state_type;

   state_type state_ff;
   logic      strobe_ff;

   assign busy       = state_ff != S_IDLE;
   assign csr_ready  = state_ff == S_IDLE;
   assign rsp_strobe = strobe_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load      = start;
            cmd.cfg_write = csr_valid;
         end
         S_GRANT:     cmd.grant     = 1'b1;
         S_ADD:       cmd.add_end   = 1'b1;
         S_SUB:       cmd.sub_freed = 1'b1;
         S_COMMIT:    cmd.commit    = 1'b1;
         S_CLOSE:     cmd.close     = 1'b1;
         S_RET_WAIT:  cmd          = '0;
         S_RET_CHECK: begin
            cmd.ret_pop  = stat.ret_more;
            cmd.ret_done = !stat.ret_more;
         end
         S_VOID:      cmd.void_op   = 1'b1;
         default:     cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff inside {S_COMMIT, S_CLOSE, S_VOID}) ||
                      ((state_ff == S_RET_CHECK) && !stat.ret_more);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  case (req_operation)
                     OP_RESERVE:  state_ff <= S_GRANT;
                     OP_CLOSE:    state_ff <= S_CLOSE;
                     OP_COMPLETE: state_ff <= S_RET_WAIT;
                     default:     state_ff <= S_VOID;
                  endcase
               end
            end
            S_GRANT:     state_ff <= S_ADD;
            S_ADD:       state_ff <= S_SUB;
            S_SUB:       state_ff <= S_COMMIT;
            S_RET_WAIT:  state_ff <= S_RET_CHECK;
            S_RET_CHECK: state_ff <= stat.ret_more ? S_RET_WAIT : S_IDLE;
            S_COMMIT, S_CLOSE, S_VOID: state_ff <= S_IDLE;
            default:     state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
